### src/hll_pkg.sv
// shared types, constants and codes for the hyperloglog sketch unit
// no dependencies
`default_nettype none
package hll_pkg;

  localparam int MAX_PRECISION = 16;
  localparam int DEPTH = 1 << MAX_PRECISION;
  localparam int ADDR_W = MAX_PRECISION;
  localparam int RANK_W = 5;
  localparam int PREC_W = 5;
  localparam int SUM_W = 33 + MAX_PRECISION;
  localparam int CNT_W = MAX_PRECISION + 1;
  localparam int EST_W = 45;

  localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(14);
  localparam logic [PREC_W-1:0] PREC_MIN = PREC_W'(4);
  localparam logic [PREC_W-1:0] PREC_MAX = PREC_W'(MAX_PRECISION);

  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;
  localparam logic [63:0] LARGE_LIM = 64'd614891469123651720;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_EST = 1'b1;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_LARGE  = 2'd2
  } hll_mode_t;

  typedef struct packed {
    logic        command;
    logic [31:0] hash_value;
  } hll_in_t;

  typedef struct packed {
    logic [EST_W-1:0] estimate;
    logic [16:0]      empty_count;
    logic [1:0]       correction_mode;
  } hll_out_t;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] idx;
    logic [RANK_W-1:0] rho;
    logic [PREC_W-1:0] prec;
  } hll_cmd_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_ADD_WR,
    BK_SCAN,
    BK_SCAN_END,
    BK_MATH
  } hll_back_state_t;

  typedef enum logic [3:0] {
    MT_IDLE,
    MT_DIV1,
    MT_DIV2,
    MT_CHECK,
    MT_NORM,
    MT_SQ_MUL,
    MT_SQ_UPD,
    MT_LN_MUL,
    MT_FINISH
  } hll_math_state_t;

endpackage
`default_nettype wire

### src/hll_front.sv
// front end: precision register, word classification and command queue
// depends on hll_pkg
`default_nettype none
module hll_front import hll_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire hll_in_t           in_word,
  input  wire logic              cfg_we,
  input  wire logic [PREC_W-1:0] cfg_wdata,
  input  wire logic              clearing,
  output logic                   q_valid,
  output hll_cmd_t               q_head,
  input  wire logic              q_pop
);

  function automatic logic [5:0] clz32(input logic [31:0] x);
    logic [5:0] n;
    logic       found;
    n = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && x[i]) begin
        n = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic [PREC_W-1:0] prec_r;
  hll_cmd_t          fifo_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              push;
  hll_cmd_t          entry;
  logic [31:0]       w;
  logic [5:0]        rho_raw, rho_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r <= PREC_RESET;
    end else if (cfg_we) begin
      if (cfg_wdata < PREC_MIN) prec_r <= PREC_MIN;
      else if (cfg_wdata > PREC_MAX) prec_r <= PREC_MAX;
      else prec_r <= cfg_wdata;
    end
  end

  always_comb begin
    w = in_word.hash_value << prec_r;
    rho_raw = clz32(w) + 6'd1;
    rho_cap = 6'd33 - 6'(prec_r);
    entry.cmd = in_word.command;
    entry.idx = ADDR_W'(in_word.hash_value >> (6'd32 - 6'(prec_r)));
    entry.rho = (rho_raw > rho_cap) ? rho_cap[RANK_W-1:0] : rho_raw[RANK_W-1:0];
    entry.prec = prec_r;
  end

  assign busy = (cnt_r == 2'd2) || clearing;
  assign push = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

### src/hll_math.sv
// estimate arithmetic: serial dividers, base-2 log by squaring, ln scaling
// depends on hll_pkg
`default_nettype none
module hll_math import hll_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  sum,
  input  wire logic [CNT_W-1:0]  zeros,
  input  wire logic [PREC_W-1:0] prec,
  output logic                   done,
  output hll_out_t               result
);

  hll_math_state_t st_r, st_nxt;
  logic [127:0] num_r, num_nxt;
  logic [64:0]  rem_r, rem_nxt;
  logic [63:0]  den_r, den_nxt;
  logic [6:0]   bit_cnt_r, bit_cnt_nxt;
  logic [29:0]  aden_r, aden_nxt;
  logic [CNT_W-1:0]  zeros_r, zeros_nxt;
  logic [PREC_W-1:0] prec_r, prec_nxt;
  logic [1:0]   mode_r, mode_nxt;
  logic [63:0]  y_r, y_nxt;
  logic [5:0]   k_r, k_nxt;
  logic [63:0]  lg_r, lg_nxt;
  logic [5:0]   lbit_r, lbit_nxt;
  logic [63:0]  lbase_r, lbase_nxt;
  logic [5:0]   shift_r, shift_nxt;
  logic [63:0]  mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic [127:0] acc_r, acc_nxt, acc_fin;
  logic [63:0]  prod_r, prod_nxt;
  logic [1:0]   prod_sh_r, prod_sh_nxt;
  logic [2:0]   mul_cnt_r, mul_cnt_nxt;
  hll_out_t     result_r, result_nxt;
  logic         done_r, done_nxt;

  logic [64:0]  rem_sh;
  logic         q_bit;
  logic [127:0] step_num;
  logic [64:0]  step_rem;
  logic [29:0]  anum_s, aden_s;
  logic [63:0]  lim_lin, ysq, lg_set, l2;
  logic [127:0] rnd, fin_prod, fin_sum;
  logic [63:0]  fin_lo;
  logic [31:0]  pa, pb;

  always_comb begin
    rem_sh = {rem_r[63:0], num_r[127]};
    q_bit = (rem_sh >= {1'b0, den_r});
    step_rem = q_bit ? (rem_sh - {1'b0, den_r}) : rem_sh;
    step_num = {num_r[126:0], q_bit};
  end

  always_comb begin
    unique case (mul_cnt_r)
      3'd0:    begin pa = mul_a_r[31:0];  pb = mul_b_r[31:0];  end
      3'd1:    begin pa = mul_a_r[31:0];  pb = mul_b_r[63:32]; end
      3'd2:    begin pa = mul_a_r[63:32]; pb = mul_b_r[31:0];  end
      default: begin pa = mul_a_r[63:32]; pb = mul_b_r[63:32]; end
    endcase
    acc_fin = acc_r + ({64'd0, prod_r} << (7'd32 * 7'(prod_sh_r)));
  end

  always_comb begin
    unique case (prec)
      PREC_W'(4): begin anum_s = 30'd673; aden_s = 30'd1000; end
      PREC_W'(5): begin anum_s = 30'd697; aden_s = 30'd1000; end
      PREC_W'(6): begin anum_s = 30'd709; aden_s = 30'd1000; end
      default: begin
        anum_s = 30'd7213 << prec;
        aden_s = (30'd10000 << prec) + 30'd10790;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    bit_cnt_nxt = bit_cnt_r;
    aden_nxt = aden_r;
    zeros_nxt = zeros_r;
    prec_nxt = prec_r;
    mode_nxt = mode_r;
    y_nxt = y_r;
    k_nxt = k_r;
    lg_nxt = lg_r;
    lbit_nxt = lbit_r;
    lbase_nxt = lbase_r;
    shift_nxt = shift_r;
    mul_a_nxt = mul_a_r;
    mul_b_nxt = mul_b_r;
    acc_nxt = acc_r;
    prod_nxt = prod_r;
    prod_sh_nxt = prod_sh_r;
    mul_cnt_nxt = mul_cnt_r;
    result_nxt = result_r;
    done_nxt = 1'b0;
    lim_lin = 64'd5 << (6'(prec_r) + 6'd31);
    rnd = num_r + 128'h8000_0000;
    ysq = acc_fin[125:62];
    lg_set = lg_r | (64'd1 << lbit_r);
    l2 = 64'd0;
    fin_prod = {64'd0, y_r} << shift_r;
    fin_sum = fin_prod + (128'd1 << 47);
    fin_lo = fin_sum[111:48];

    if (st_r == MT_SQ_MUL || st_r == MT_LN_MUL) begin
      mul_cnt_nxt = mul_cnt_r + 3'd1;
      prod_nxt = pa * pb;
      prod_sh_nxt = (mul_cnt_r == 3'd0) ? 2'd0 : (mul_cnt_r == 3'd3) ? 2'd2 : 2'd1;
      if (mul_cnt_r != 3'd0) acc_nxt = acc_fin;
    end

    unique case (st_r)
      MT_IDLE: begin
        if (start) begin
          num_nxt = {64'({34'd0, anum_s} << (6'(prec) * 6'd2)), 64'd0};
          den_nxt = 64'(sum);
          rem_nxt = 65'd0;
          bit_cnt_nxt = 7'd0;
          aden_nxt = aden_s;
          zeros_nxt = zeros;
          prec_nxt = prec;
          st_nxt = MT_DIV1;
        end
      end
      MT_DIV1, MT_DIV2: begin
        num_nxt = step_num;
        rem_nxt = step_rem;
        bit_cnt_nxt = bit_cnt_r + 7'd1;
        if (bit_cnt_r == 7'd127) begin
          rem_nxt = 65'd0;
          den_nxt = 64'(aden_r);
          st_nxt = (st_r == MT_DIV1) ? MT_DIV2 : MT_CHECK;
        end
      end
      MT_CHECK: begin
        k_nxt = 6'd62;
        if (zeros_r != '0 && num_r[127:64] == 64'd0 && num_r[63:0] <= lim_lin) begin
          mode_nxt = MODE_LINEAR;
          y_nxt = 64'(zeros_r);
          lbase_nxt = 64'(prec_r) << 48;
          shift_nxt = 6'(prec_r);
          st_nxt = MT_NORM;
        end else if (num_r[127:64] == 64'd0 && num_r[63:0] > LARGE_LIM) begin
          mode_nxt = MODE_LARGE;
          y_nxt = 64'd0 - num_r[63:0];
          lbase_nxt = 64'd64 << 48;
          shift_nxt = 6'd32;
          st_nxt = MT_NORM;
        end else begin
          result_nxt.correction_mode = MODE_RAW;
          result_nxt.empty_count = zeros_r;
          result_nxt.estimate = (rnd[127:77] != '0) ? {EST_W{1'b1}} : rnd[76:32];
          done_nxt = 1'b1;
          st_nxt = MT_IDLE;
        end
      end
      MT_NORM: begin
        if (y_r[63]) begin
          y_nxt = y_r >> 1;
          k_nxt = 6'd63;
          lg_nxt = 64'd63 << 48;
          lbit_nxt = 6'd47;
          mul_cnt_nxt = 3'd0;
          acc_nxt = '0;
          st_nxt = MT_SQ_MUL;
        end else if (y_r[62]) begin
          lg_nxt = 64'(k_r) << 48;
          lbit_nxt = 6'd47;
          mul_cnt_nxt = 3'd0;
          acc_nxt = '0;
          st_nxt = MT_SQ_MUL;
        end else begin
          y_nxt = y_r << 1;
          k_nxt = k_r - 6'd1;
        end
        mul_a_nxt = y_nxt;
        mul_b_nxt = y_nxt;
      end
      MT_SQ_MUL: begin
        if (mul_cnt_r == 3'd4) begin
          y_nxt = ysq;
          st_nxt = MT_SQ_UPD;
        end
      end
      MT_SQ_UPD: begin
        if (y_r[63]) begin
          y_nxt = y_r >> 1;
          lg_nxt = lg_set;
        end
        mul_a_nxt = y_nxt;
        mul_b_nxt = y_nxt;
        mul_cnt_nxt = 3'd0;
        acc_nxt = '0;
        if (lbit_r == 6'd0) begin
          l2 = lbase_r - lg_nxt;
          mul_a_nxt = l2;
          mul_b_nxt = LN2_Q64;
          st_nxt = MT_LN_MUL;
        end else begin
          lbit_nxt = lbit_r - 6'd1;
          st_nxt = MT_SQ_MUL;
        end
      end
      MT_LN_MUL: begin
        if (mul_cnt_r == 3'd4) begin
          y_nxt = acc_fin[127:64];
          st_nxt = MT_FINISH;
        end
      end
      MT_FINISH: begin
        result_nxt.correction_mode = mode_r;
        result_nxt.empty_count = zeros_r;
        result_nxt.estimate = (fin_lo[63:45] != '0) ? {EST_W{1'b1}} : fin_lo[44:0];
        done_nxt = 1'b1;
        st_nxt = MT_IDLE;
      end
      default: st_nxt = MT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= MT_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    aden_r <= aden_nxt;
    zeros_r <= zeros_nxt;
    prec_r <= prec_nxt;
    mode_r <= mode_nxt;
    y_r <= y_nxt;
    k_r <= k_nxt;
    lg_r <= lg_nxt;
    lbit_r <= lbit_nxt;
    lbase_r <= lbase_nxt;
    shift_r <= shift_nxt;
    mul_a_r <= mul_a_nxt;
    mul_b_r <= mul_b_nxt;
    acc_r <= acc_nxt;
    prod_r <= prod_nxt;
    prod_sh_r <= prod_sh_nxt;
    mul_cnt_r <= mul_cnt_nxt;
    result_r <= result_nxt;
  end

  assign done = done_r;
  assign result = result_r;

endmodule
`default_nettype wire

### src/hll_back.sv
// back end: rank memory, clearing pass, add read-modify-write, estimate scan
// depends on hll_pkg
`default_nettype none
module hll_back import hll_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire hll_cmd_t          q_head,
  output logic                   q_pop,
  output logic                   clearing,
  output logic                   math_start,
  output logic [SUM_W-1:0]       math_sum,
  output logic [CNT_W-1:0]       math_zeros,
  output logic [PREC_W-1:0]      math_prec,
  input  wire logic              math_done
);

  logic [RANK_W-1:0] rank_mem [DEPTH];
  logic [RANK_W-1:0] rd_data_r;

  hll_back_state_t st_r, st_nxt;
  hll_cmd_t          cur_r, cur_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  zeros_r, zeros_nxt;
  logic              vld_r, vld_nxt;
  logic              mstart_r, mstart_nxt;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [RANK_W-1:0] wr_data;
  logic              we;
  logic [CNT_W-1:0]  m_last;
  logic [SUM_W-1:0]  term;

  always_ff @(posedge clk) begin
    if (we) rank_mem[wr_addr] <= wr_data;
    rd_data_r <= rank_mem[rd_addr];
  end

  always_comb begin
    st_nxt = st_r;
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    zeros_nxt = zeros_r;
    vld_nxt = 1'b0;
    mstart_nxt = 1'b0;
    q_pop = 1'b0;
    we = 1'b0;
    wr_addr = cnt_r[ADDR_W-1:0];
    wr_data = '0;
    rd_addr = cnt_r[ADDR_W-1:0];
    m_last = (CNT_W'(1) << cur_r.prec) - CNT_W'(1);
    term = SUM_W'(1) << (6'd32 - 6'(rd_data_r));
    if (vld_r) begin
      sum_nxt = sum_r + term;
      if (rd_data_r == '0) zeros_nxt = zeros_r + CNT_W'(1);
    end

    unique case (st_r)
      BK_CLEAR: begin
        we = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r[ADDR_W-1:0] == {ADDR_W{1'b1}}) st_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        rd_addr = q_head.idx;
        if (q_valid) begin
          q_pop = 1'b1;
          cur_nxt = q_head;
          if (q_head.cmd == CMD_ADD) begin
            st_nxt = BK_ADD_WR;
          end else begin
            cnt_nxt = '0;
            sum_nxt = '0;
            zeros_nxt = '0;
            st_nxt = BK_SCAN;
          end
        end
      end
      BK_ADD_WR: begin
        wr_addr = cur_r.idx;
        wr_data = cur_r.rho;
        we = (cur_r.rho > rd_data_r);
        st_nxt = BK_IDLE;
      end
      BK_SCAN: begin
        vld_nxt = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == m_last) st_nxt = BK_SCAN_END;
      end
      BK_SCAN_END: begin
        mstart_nxt = 1'b1;
        st_nxt = BK_MATH;
      end
      BK_MATH: begin
        if (math_done) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_CLEAR;
      cnt_r <= '0;
      vld_r <= 1'b0;
      mstart_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
      mstart_r <= mstart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    sum_r <= sum_nxt;
    zeros_r <= zeros_nxt;
  end

  assign clearing = (st_r == BK_CLEAR);
  assign math_start = mstart_r;
  assign math_sum = sum_r;
  assign math_zeros = zeros_r;
  assign math_prec = cur_r.prec;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop) else $error("queue popped during clearing pass");
  a_done_in_math: assert property (@(posedge clk) disable iff (!rst_n)
    math_done |-> (st_r == BK_MATH)) else $error("estimate finished outside math wait");
  a_add_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_ADD_WR) |=> (st_r == BK_IDLE)) else $error("add did not return to idle");
  a_start_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    math_start |-> $past(st_r == BK_SCAN_END)) else $error("math start without scan end");

endmodule
`default_nettype wire

### src/hyperloglog_cardinality_sketch_unit.sv
// top level of the hyperloglog sketch unit: front, back and estimate math
// depends on hll_pkg, hll_front, hll_back, hll_math
//
//   channel   ports                          word
//   input     start, busy, in_word           hll_in_t
//   result    out_valid, out_word            hll_out_t
//   config    cfg_we, cfg_wdata              precision
//
// after reset a clearing pass over all 65536 rank entries holds busy high
// an add in the back end is a memory read, then a write if the new rank is larger
// an estimate scans the m ranks, runs two serial divisions and,
// for the corrected modes, a base-2 log by squaring and ln scaling
// a 2-word queue lets the front accept while the back works; results are strobed
`default_nettype none
module hyperloglog_cardinality_sketch_unit import hll_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire hll_in_t           in_word,
  output logic                   out_valid,
  output hll_out_t               out_word,
  input  wire logic              cfg_we,
  input  wire logic [PREC_W-1:0] cfg_wdata
);

  logic              clearing, q_valid, q_pop;
  hll_cmd_t          q_head;
  logic              math_start, math_done;
  logic [SUM_W-1:0]  math_sum;
  logic [CNT_W-1:0]  math_zeros;
  logic [PREC_W-1:0] math_prec;

  hll_front u_front (
    .clk, .rst_n, .start, .busy, .in_word, .cfg_we, .cfg_wdata,
    .clearing, .q_valid, .q_head, .q_pop
  );

  hll_back u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .clearing,
    .math_start, .math_sum, .math_zeros, .math_prec, .math_done
  );

  hll_math u_math (
    .clk, .rst_n, .start(math_start), .sum(math_sum), .zeros(math_zeros),
    .prec(math_prec), .done(math_done), .result(out_word)
  );

  assign out_valid = math_done;

endmodule
`default_nettype wire
